// ===== hdl/qmi_pkg.sv =====
// ----------------------------------------------------------------------------
// qmi_pkg
// Command and status codes and shared types for the queue with middle insert.
// ----------------------------------------------------------------------------
`default_nettype none

package qmi_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_MIDDLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP         = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic push_back;
        logic push_mid;
        logic pop;
    } qmi_op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qmi_flags_t;

endpackage

`default_nettype wire

// ===== hdl/qmi_store.sv =====
// ----------------------------------------------------------------------------
// qmi_store
// Row of entry registers and the fill count; applies one push or pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qmi_store
    import qmi_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire qmi_op_t                  op,
    input  wire logic signed [DATA_W-1:0] value,
    output qmi_flags_t                    flags,
    output logic signed [DATA_W-1:0]      front
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] entries_reg [DEPTH];
    logic signed [DATA_W-1:0] entries_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] pos;
    logic [CW-1:0] last;

    assign mid_sum = {1'b0, count_reg} + {{CW{1'b0}}, 1'b1};
    assign pos     = op.push_back ? count_reg : mid_sum[CW:1];
    assign last    = count_reg - {{(CW-1){1'b0}}, 1'b1};

    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == CW'(DEPTH));
    assign front       = entries_reg[0];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int UP = (i == DEPTH - 1) ? i : i + 1;
        localparam int DN = (i == 0) ? 0 : i - 1;
        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (op.push_back || op.push_mid)
            begin
                if (CW'(i) == pos)
                    entries_next[i] = value;
                else if (CW'(i) > pos && CW'(i) <= count_reg)
                    entries_next[i] = entries_reg[DN];
            end
            else if (op.pop)
            begin
                if (CW'(i) < last)
                    entries_next[i] = entries_reg[UP];
                else if (CW'(i) == last)
                    entries_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.push_back || op.push_mid)
            count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
        else if (op.pop)
            count_next = last;
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        op.pop |-> count_reg != '0)
        else $error("pop applied to empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (op.push_back || op.push_mid) |-> count_reg != CW'(DEPTH))
        else $error("push applied to full queue");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op.push_back || op.push_mid) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not advance count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op.pop && !op.push_back && !op.push_mid) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not reduce count");

endmodule

`default_nettype wire

// ===== hdl/queue_with_middle_insert_top.sv =====
// ----------------------------------------------------------------------------
// queue_with_middle_insert_top
// Bounded queue of signed 32-bit values with push back, push middle and pop.
// ----------------------------------------------------------------------------
// The block takes one command per clock while cmd_stall is low. A command is
// captured in an input register and applied to the entry row once it executes,
// so a result (pop, pop on empty, or dropped push) passes through the input
// register and the result register. Entries shift in place, so throughput is
// one command per cycle; cmd_stall rises only when a command that yields a
// result waits behind an unread result held by res_stall.
`default_nettype none

module queue_with_middle_insert_top
    import qmi_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    output logic                          cmd_stall,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic [STAT_W-1:0]             status,
    output logic signed [DATA_W-1:0]      popped_value
);

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [CMD_W-1:0]         s1_cmd_reg;
    logic signed [DATA_W-1:0] s1_value_reg;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;

    qmi_op_t                  op;
    qmi_flags_t               flags;
    logic signed [DATA_W-1:0] front;
    logic                     is_push;
    logic                     is_pop;
    logic                     has_result;
    logic                     out_free;
    logic                     exec;
    logic                     cmd_accept;

    assign is_push    = (s1_cmd_reg == CMD_PUSH_BACK) || (s1_cmd_reg == CMD_PUSH_MIDDLE);
    assign is_pop     = (s1_cmd_reg == CMD_POP);
    assign has_result = is_pop || (is_push && flags.full);
    assign out_free   = !res_valid_reg || !res_stall;
    assign exec       = s1_valid_reg && (!has_result || out_free);
    assign cmd_stall  = s1_valid_reg && !exec;
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign op.push_back = exec && (s1_cmd_reg == CMD_PUSH_BACK) && !flags.full;
    assign op.push_mid  = exec && (s1_cmd_reg == CMD_PUSH_MIDDLE) && !flags.full;
    assign op.pop       = exec && is_pop && !flags.empty;

    qmi_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .value (s1_value_reg),
        .flags (flags),
        .front (front)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_accept)
            s1_valid_next = 1'b1;
        else if (exec)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        if (exec && has_result)
        begin
            res_valid_next = 1'b1;
            popped_next    = '0;
            if (!is_pop)
                status_next = ST_FULL;
            else if (flags.empty)
                status_next = ST_EMPTY;
            else
            begin
                status_next = ST_OK;
                popped_next = front;
            end
        end
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_cmd_reg   <= command;
            s1_value_reg <= value;
        end
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a pending command");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> $stable(status_reg) && $stable(popped_reg))
        else $error("held result overwritten");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg != ST_OK) |-> popped_reg == '0)
        else $error("error result carries data");

endmodule

`default_nettype wire

// ===== tb/queue_with_middle_insert_top_tb.sv =====
// ----------------------------------------------------------------------------
// queue_with_middle_insert_top_tb
// Self-checking bench for the bounded queue with push back, push middle and
// pop. A shadow queue predicts each result as commands are accepted. Results
// are matched in order against that prediction. Traffic covers extreme values,
// empty and full edges and unused codes, with bursty commands and stalled
// results.
// ----------------------------------------------------------------------------
module queue_with_middle_insert_top_tb;
    import qmi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 1250;
    localparam int MAX_REPORTS = 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] data;
    } cmd_item_t;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    logic [CMD_W-1:0] command = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic signed [DATA_W-1:0] popped_value;

    cmd_item_t pending_cmds[$];
    queue_result_t expected_results[$];
    logic signed [DATA_W-1:0] shadow_queue[$];

    int err_count = 0;
    int total_items = 0;
    int accepted_items = 0;
    int gen_count = 0;
    bit cmd_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_run_left = 0;
    int stall_pct = 0;

    queue_with_middle_insert_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .value        (value),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .popped_value (popped_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    task automatic add_item(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] data);
        cmd_item_t it;
        it.cmd = cmd;
        it.data = data;
        pending_cmds.push_back(it);
        total_items++;
        if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_MIDDLE)
        begin
            if (gen_count < QUEUE_DEPTH)
            begin
                gen_count++;
            end
        end
        else if (cmd == CMD_POP && gen_count > 0)
        begin
            gen_count--;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = '0;
                default: v = -1;
            endcase
        end
        return v;
    endfunction

    function automatic logic [CMD_W-1:0] pick_push();
        return ($urandom_range(1) == 0) ? CMD_PUSH_BACK : CMD_PUSH_MIDDLE;
    endfunction

    task automatic apply_queue_command(input logic [CMD_W-1:0] cmd,
                                       input logic signed [DATA_W-1:0] data);
        queue_result_t res;
        int pos;
        res.data = '0;
        if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_MIDDLE)
        begin
            if (shadow_queue.size() >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
                expected_results.push_back(res);
            end
            else
            begin
                pos = (cmd == CMD_PUSH_BACK) ? shadow_queue.size()
                                             : (shadow_queue.size() + 1) / 2;
                if (pos == shadow_queue.size())
                begin
                    shadow_queue.push_back(data);
                end
                else
                begin
                    shadow_queue.insert(pos, data);
                end
            end
        end
        else if (cmd == CMD_POP)
        begin
            if (shadow_queue.size() == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.status = ST_OK;
                res.data = shadow_queue.pop_front();
            end
            expected_results.push_back(res);
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t exp_res;
        cmd_taken = 1'b0;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                cmd_taken = 1'b1;
                accepted_items++;
                apply_queue_command(command, value);
            end
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result status %0d value %0d",
                                              status, popped_value));
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, exp_res.status));
                    end
                    if (popped_value !== exp_res.data)
                    begin
                        report_mismatch($sformatf("popped_value %0d, expected %0d",
                                                  popped_value, exp_res.data));
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        cmd_item_t it;
        if (rst_n && (!cmd_valid || cmd_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                it = pending_cmds.pop_front();
                command <= it.cmd;
                value <= it.data;
                cmd_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(2) == 0) ? $urandom_range(1, 8) : 0;
                end
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_run_left == 0)
        begin
            stall_run_left = $urandom_range(5, 60);
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        stall_run_left--;
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int issued;
        int seg_len;
        int mode;
        int extra;
        logic [CMD_W-1:0] cmd;

        add_item(CMD_POP, VAL_MAX);
        add_item(CMD_UNUSED, 32'sh1234_5678);
        add_item(CMD_PUSH_MIDDLE, VAL_MAX);
        add_item(CMD_PUSH_BACK, VAL_MIN);
        add_item(CMD_PUSH_MIDDLE, '0);
        add_item(CMD_PUSH_BACK, -1);
        add_item(CMD_PUSH_MIDDLE, 32'sh5555_5555);
        add_item(CMD_UNUSED, -1);
        add_item(CMD_PUSH_MIDDLE, 32'shAAAA_AAAA);
        add_item(CMD_PUSH_BACK, 32'sh0000_0001);
        add_item(CMD_POP, '0);
        add_item(CMD_PUSH_MIDDLE, 32'sh7FFF_0000);
        add_item(CMD_POP, '0);
        add_item(CMD_POP, '0);
        add_item(CMD_POP, '0);
        add_item(CMD_POP, '0);
        add_item(CMD_POP, '0);
        add_item(CMD_POP, '0);
        add_item(CMD_POP, '0);
        add_item(CMD_POP, -1);

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            mode = $urandom_range(7);
            if (mode == 0)
            begin
                while (gen_count < QUEUE_DEPTH)
                begin
                    add_item(pick_push(), pick_value());
                    issued++;
                end
                extra = $urandom_range(1, 4);
                repeat (extra)
                begin
                    add_item(pick_push(), pick_value());
                    issued++;
                end
                if ($urandom_range(1) == 0)
                begin
                    add_item(CMD_POP, pick_value());
                    add_item(pick_push(), pick_value());
                    add_item(pick_push(), pick_value());
                    issued += 3;
                end
                while (gen_count > 0)
                begin
                    add_item(CMD_POP, pick_value());
                    issued++;
                end
                add_item(CMD_POP, pick_value());
                issued++;
            end
            else
            begin
                seg_len = $urandom_range(10, 120);
                repeat (seg_len)
                begin
                    if ($urandom_range(32) == 0)
                    begin
                        add_item(CMD_UNUSED, pick_value());
                    end
                    else
                    begin
                        case (mode)
                            1, 2: cmd = ($urandom_range(99) < 80) ? pick_push() : CMD_POP;
                            3, 4: cmd = ($urandom_range(99) < 80) ? CMD_POP : pick_push();
                            default: cmd = ($urandom_range(1) == 0) ? pick_push() : CMD_POP;
                        endcase
                        add_item(cmd, pick_value());
                        issued++;
                    end
                end
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_items < total_items)
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end

        if (err_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/qmi_pkg.sv
hdl/qmi_store.sv
hdl/queue_with_middle_insert_top.sv
tb/queue_with_middle_insert_top_tb.sv
